// ===== src/top_fraction_color_average_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cloud colour average block
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef TOP_FRACTION_COLOR_AVERAGE_MACROS_SVH
`define TOP_FRACTION_COLOR_AVERAGE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa assertion failed");
// Next-cycle implication, checked out of reset.
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa assertion failed");
`else
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/cfa_pkg.sv =====
// ---------------------------------------------------------------------------
// cfa_pkg
// Sizes, types and helper functions shared by the colour average block.
// ---------------------------------------------------------------------------
package cfa_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int GRAY_LEVELS = 256;
  localparam int PIX_AW      = $clog2(MAX_PIXELS);
  localparam int CNT_W       = PIX_AW + 1;
  localparam int HIST_AW     = $clog2(GRAY_LEVELS);
  localparam int CH_W        = 8;
  localparam int PIX_W       = HIST_AW + 3 * CH_W;
  localparam int SUM_W       = CH_W + PIX_AW;
  localparam int RATIO_W     = 17;
  localparam int RATIO_ONE   = 65536;
  localparam int RATIO_RESET = 6554;
  localparam int BIT_W       = $clog2(CH_W);

  typedef logic [2:0][SUM_W-1:0] rgb_sum_t;
  typedef logic [2:0][CH_W-1:0]  rgb_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_HINC,
    ST_KCALC,
    ST_THR_RD,
    ST_THR_CHK,
    ST_SUM_RD,
    ST_SUM_CHK,
    ST_DIV,
    ST_LOAD
  } cfa_state_t;

  // Saturate a gray level to the histogram range.
  function automatic logic [HIST_AW-1:0] sat_gray(input logic [CH_W-1:0] g);
    logic [HIST_AW-1:0] res;
    if (32'(g) >= GRAY_LEVELS) res = HIST_AW'(GRAY_LEVELS - 1);
    else res = HIST_AW'(g);
    return res;
  endfunction

endpackage

// ===== src/cfa_if.sv =====
// ---------------------------------------------------------------------------
// cfa channel interfaces
// Valid/ready channels for pixel words and result words.
// ---------------------------------------------------------------------------
interface cfa_in_if;
  logic       valid;
  logic       ready;
  logic       is_cloud;
  logic [7:0] gray;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;
  modport source (output valid, is_cloud, gray, red, green, blue, last, input ready);
  modport sink   (input valid, is_cloud, gray, red, green, blue, last, output ready);
endinterface

interface cfa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  avg_red;
  logic [7:0]  avg_green;
  logic [7:0]  avg_blue;
  logic [16:0] bright_count;
  logic        valid_res;
  modport source (output valid, avg_red, avg_green, avg_blue, bright_count, valid_res,
                  input ready);
  modport sink   (input valid, avg_red, avg_green, avg_blue, bright_count, valid_res,
                  output ready);
endinterface

// ===== src/cfa_ram.sv =====
// ---------------------------------------------------------------------------
// cfa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cfa_div.sv =====
// ---------------------------------------------------------------------------
// cfa_div
// Restoring divider producing three 8-bit channel means, one bit a cycle.
// ---------------------------------------------------------------------------
module cfa_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [cfa_pkg::CNT_W-1:0] k,
  input  cfa_pkg::rgb_sum_t       sums,
  output logic                    done,
  output cfa_pkg::rgb_t           quot
);
  import cfa_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  rgb_sum_t         rem_r, rem_nxt;
  rgb_t             q_r, q_nxt;
  logic [SUM_W:0]   dsh;

  // One quotient bit per channel per cycle, most significant first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsh      = (SUM_W + 1)'(k) << bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = BIT_W'(CH_W - 1);
      rem_nxt  = sums;
      q_nxt    = '0;
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        if ({1'b0, rem_r[c]} >= dsh) begin
          rem_nxt[c]      = SUM_W'({1'b0, rem_r[c]} - dsh);
          q_nxt[c][bit_r] = 1'b1;
        end
      end
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== src/top_fraction_color_average.sv =====
// Operation: each pixel word is accepted in ST_IDLE; a cloud pixel is stored and then
// does a histogram read-modify-write in ST_HINC. After the last pixel, ST_KCALC works
// out k, the histogram is scanned from the top gray level (ST_THR_RD, ST_THR_CHK),
// every stored cloud pixel is read back (ST_SUM_RD, ST_SUM_CHK), the divider runs, and
// after ST_LOAD the 256-entry histogram is cleared. No new pixel word is taken outside
// ST_IDLE. Synchronous reset runs the histogram clear before the first pixel word is accepted; ratio resets to 6554.
// ---------------------------------------------------------------------------
// top_fraction_color_average
// Stores cloud pixels, finds the brightest fraction and averages its colour.
// ---------------------------------------------------------------------------
`include "top_fraction_color_average_macros.svh"

module top_fraction_color_average (
  input  logic                        clk,
  input  logic                        rst_n,
  cfa_in_if.sink                      in_px,
  cfa_out_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [cfa_pkg::RATIO_W-1:0] cfg_wdata
);
  import cfa_pkg::*;

  cfa_state_t           state_r, state_nxt;
  logic [RATIO_W-1:0]   ratio_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [HIST_AW-1:0]   gsat_r, gsat_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [HIST_AW-1:0]   g_r, g_nxt;
  logic [CNT_W-1:0]     above_r, above_nxt;
  logic [HIST_AW-1:0]   thr_r, thr_nxt;
  logic [CNT_W-1:0]     ties_r, ties_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [HIST_AW-1:0]   clr_r, clr_nxt;
  rgb_sum_t             sum_r, sum_nxt;
  logic                 div_start;
  logic                 div_done;
  rgb_t                 quot;

  logic                 out_valid_r;
  rgb_t                 out_avg_r;
  logic [CNT_W-1:0]     out_k_r;
  logic                 out_vres_r;
  logic                 load_out;

  logic                 pix_we;
  logic [PIX_AW-1:0]    pix_raddr;
  logic [PIX_W-1:0]     pix_rdata;
  logic                 hist_we;
  logic [HIST_AW-1:0]   hist_waddr;
  logic [CNT_W-1:0]     hist_wdata;
  logic [HIST_AW-1:0]   hist_raddr;
  logic [CNT_W-1:0]     hist_rdata;

  logic                 accept;
  logic [HIST_AW-1:0]   in_gsat;
  logic [RATIO_W-1:0]   ratio_clamp;
  logic [CNT_W+RATIO_W-1:0] prod;
  logic [CNT_W:0]       tot;
  logic [HIST_AW-1:0]   px_gray;
  logic                 take;

  assign accept      = in_px.valid && in_px.ready;
  assign in_gsat     = sat_gray(in_px.gray);
  assign ratio_clamp = (ratio_r > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE) : ratio_r;
  assign prod        = (CNT_W + RATIO_W)'(cnt_r) * (CNT_W + RATIO_W)'(ratio_clamp);
  assign tot         = {1'b0, above_r} + {1'b0, hist_rdata};
  assign px_gray     = pix_rdata[PIX_W-1 -: HIST_AW];
  assign take        = (px_gray > thr_r) || (px_gray == thr_r && ties_r != '0);

  // Pixel store and gray histogram.
  cfa_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (cnt_r[PIX_AW-1:0]),
    .wdata ({in_gsat, in_px.red, in_px.green, in_px.blue}),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  cfa_ram #(.WIDTH(CNT_W), .DEPTH(GRAY_LEVELS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // The divider takes the sums including the pixel summed in its start cycle.
  cfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .k     (k_r),
    .sums  (sum_nxt),
    .done  (div_done),
    .quot  (quot)
  );

  // Sequencer: load, threshold scan, selection sum, divide, clear.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    gsat_nxt   = gsat_r;
    last_nxt   = last_r;
    k_nxt      = k_r;
    g_nxt      = g_r;
    above_nxt  = above_r;
    thr_nxt    = thr_r;
    ties_nxt   = ties_r;
    idx_nxt    = idx_r;
    clr_nxt    = clr_r;
    sum_nxt    = sum_r;
    div_start  = 1'b0;
    load_out   = 1'b0;
    pix_we     = 1'b0;
    pix_raddr  = idx_r[PIX_AW-1:0];
    hist_we    = 1'b0;
    hist_waddr = gsat_r;
    hist_wdata = hist_rdata + 1'b1;
    hist_raddr = in_gsat;
    unique case (state_r)
      ST_CLR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        hist_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == HIST_AW'(GRAY_LEVELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          gsat_nxt = in_gsat;
          last_nxt = in_px.last;
          if (in_px.is_cloud && cnt_r < CNT_W'(MAX_PIXELS)) begin
            pix_we    = 1'b1;
            state_nxt = ST_HINC;
          end else if (in_px.last) begin
            state_nxt = ST_KCALC;
          end
        end
      end
      ST_HINC: begin
        hist_we   = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_KCALC : ST_IDLE;
      end
      ST_KCALC: begin
        k_nxt     = prod[16 +: CNT_W];
        g_nxt     = HIST_AW'(GRAY_LEVELS - 1);
        above_nxt = '0;
        state_nxt = (k_nxt == '0) ? ST_LOAD : ST_THR_RD;
      end
      ST_THR_RD: begin
        hist_raddr = g_r;
        state_nxt  = ST_THR_CHK;
      end
      ST_THR_CHK: begin
        if (tot >= {1'b0, k_r}) begin
          thr_nxt   = g_r;
          ties_nxt  = k_r - above_r;
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = ST_SUM_RD;
        end else begin
          above_nxt = tot[CNT_W-1:0];
          g_nxt     = g_r - 1'b1;
          state_nxt = ST_THR_RD;
        end
      end
      ST_SUM_RD: begin
        state_nxt = ST_SUM_CHK;
      end
      ST_SUM_CHK: begin
        if (take) begin
          sum_nxt[0] = sum_r[0] + SUM_W'(pix_rdata[2*CH_W +: CH_W]);
          sum_nxt[1] = sum_r[1] + SUM_W'(pix_rdata[CH_W +: CH_W]);
          sum_nxt[2] = sum_r[2] + SUM_W'(pix_rdata[0 +: CH_W]);
          if (px_gray == thr_r) begin
            ties_nxt = ties_r - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == cnt_r) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_SUM_RD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r) begin
          load_out  = 1'b1;
          cnt_nxt   = '0;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
    // The divider starts as the last stored pixel is checked and, if selected, summed.
    if (state_r == ST_SUM_CHK && idx_nxt == cnt_r) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ratio_r     <= RATIO_W'(RATIO_RESET);
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        ratio_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    gsat_r  <= gsat_nxt;
    last_r  <= last_nxt;
    k_r     <= k_nxt;
    g_r     <= g_nxt;
    above_r <= above_nxt;
    thr_r   <= thr_nxt;
    ties_r  <= ties_nxt;
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    if (load_out) begin
      out_avg_r  <= (k_r == '0) ? '0 : quot;
      out_k_r    <= k_r;
      out_vres_r <= (k_r != '0);
    end
  end

  // Result word register.
  assign in_px.ready          = (state_r == ST_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.avg_red      = out_avg_r[0];
  assign out_res.avg_green    = out_avg_r[1];
  assign out_res.avg_blue     = out_avg_r[2];
  assign out_res.bright_count = out_k_r;
  assign out_res.valid_res    = out_vres_r;

  `CFA_ASSERT_IMP(a_k_fits, clk, rst_n, state_r == ST_THR_RD, k_r <= cnt_r && k_r != '0)
  `CFA_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_PIXELS))
  `CFA_ASSERT_NXT(a_load_sets_valid, clk, rst_n, load_out, out_valid_r && state_r == ST_CLR)
  `CFA_ASSERT_IMP(a_no_take_in_clear, clk, rst_n, state_r == ST_CLR, !in_px.ready)

endmodule

// ===== test/top_fraction_color_average_tb.sv =====
// ---------------------------------------------------------------------------
// Cloud colour average block testbench
// Drives frames of pixel words through the block, models the brightest-fraction
// selection and floor-mean colour, and checks every result word in order.
// ---------------------------------------------------------------------------
module top_fraction_color_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  typedef struct packed {
    logic       is_cloud;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [16:0] bright_count;
    logic        valid_res;
  } average_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata = '0;

  cfa_in_if  in_px();
  cfa_out_if out_res();

  top_fraction_color_average dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state: ratio and the cloud pixels of the current frame.
  logic [RATIO_W-1:0] ratio_model = RATIO_W'(RATIO_RESET);
  pixel_t frame_pixels[$];

  pixel_t   pending_pixels[$];
  average_t expected_averages[$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_off_go = 1'b0;
  bit       hold_off_done = 1'b0;
  bit       hold_off = 1'b0;
  int       hold_off_count = 0;

  // Work out the result of a frame from the stored cloud pixels.
  function automatic average_t frame_average();
    average_t res;
    int count;
    longint r;
    int k;
    int above;
    int thr;
    int ties;
    int hist[256];
    int sums[3];
    count = frame_pixels.size();
    r = (ratio_model > RATIO_ONE) ? RATIO_ONE : ratio_model;
    k = int'((longint'(count) * r) >> 16);
    above = 0;
    thr = 0;
    sums = '{0, 0, 0};
    foreach (hist[g]) hist[g] = 0;
    foreach (frame_pixels[i]) hist[frame_pixels[i].gray]++;
    if (k > 0) begin
      for (int g = 255; g >= 0; g--) begin
        if (above + hist[g] >= k) begin
          thr = g;
          break;
        end
        above += hist[g];
      end
      ties = k - above;
      foreach (frame_pixels[i]) begin
        if (frame_pixels[i].gray > thr ||
            (frame_pixels[i].gray == thr && ties > 0)) begin
          if (frame_pixels[i].gray == thr) ties--;
          sums[0] += frame_pixels[i].red;
          sums[1] += frame_pixels[i].green;
          sums[2] += frame_pixels[i].blue;
        end
      end
    end
    res.avg_red      = (k > 0) ? 8'(sums[0] / k) : 8'd0;
    res.avg_green    = (k > 0) ? 8'(sums[1] / k) : 8'd0;
    res.avg_blue     = (k > 0) ? 8'(sums[2] / k) : 8'd0;
    res.bright_count = 17'(k);
    res.valid_res    = (k > 0);
    return res;
  endfunction

  // Account for a pixel word the block has accepted.
  task automatic absorb_pixel(input pixel_t px);
    if (px.is_cloud && frame_pixels.size() < MAX_PIXELS)
      frame_pixels.insert(frame_pixels.size(), px);
    if (px.last) begin
      expected_averages.insert(expected_averages.size(), frame_average());
      frame_pixels.delete();
    end
  endtask

  // Driver: offers queued pixel words, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
      {in_px.is_cloud, in_px.gray, in_px.red, in_px.green, in_px.blue, in_px.last}
        <= '0;
    end else begin
      if (in_px.valid && in_px.ready) begin
        absorb_pixel(pending_pixels.pop_front());
      end
      if (!(in_px.valid && !in_px.ready)) begin
        if (pending_pixels.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_px.valid <= 1'b1;
          {in_px.is_cloud, in_px.gray, in_px.red, in_px.green, in_px.blue, in_px.last}
            <= pending_pixels[0];
        end else begin
          in_px.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted once it is requested.
  always @(posedge clk) begin
    if (hold_off_go && !hold_off_done) begin
      if (hold_off_count < 3000) begin
        hold_off_count <= hold_off_count + 1;
        hold_off <= 1'b1;
      end else begin
        hold_off <= 1'b0;
        hold_off_done <= 1'b1;
      end
    end
  end

  // Monitor: applies back-pressure and checks each result word.
  always @(posedge clk) begin
    average_t got;
    average_t want;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        got = {out_res.avg_red, out_res.avg_green, out_res.avg_blue,
               out_res.bright_count, out_res.valid_res};
        if (expected_averages.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result word %h", got);
        end else begin
          want = expected_averages.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected r%0d g%0d b%0d k%0d v%0d, got r%0d g%0d b%0d k%0d v%0d",
                       want.avg_red, want.avg_green, want.avg_blue, want.bright_count,
                       want.valid_res, got.avg_red, got.avg_green, got.avg_blue,
                       got.bright_count, got.valid_res);
          end
        end
      end
      if (hold_off) begin
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  function automatic pixel_t random_pixel(input bit last_px);
    pixel_t px;
    px.is_cloud = ($urandom_range(3, 0) != 0);
    px.gray     = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(3, 0) * 85)
                                               : 8'($urandom);
    px.red      = 8'($urandom);
    px.green    = 8'($urandom);
    px.blue     = 8'($urandom);
    px.last     = last_px;
    return px;
  endfunction

  // Queue one frame of random pixels, mostly short.
  task automatic queue_frame(input int length);
    for (int i = 0; i < length; i++)
      pending_pixels.insert(pending_pixels.size(), random_pixel(i == length - 1));
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || in_px.valid || expected_averages.size() > 0)
      @(posedge clk);
    // Allow for the histogram clear after the last frame.
    repeat (400) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ratio_model = value;
    @(posedge clk);
  endtask

  initial begin
    logic [RATIO_W-1:0] ratios[7];
    int idle_pct[4];
    int stall_pct[4];
    pixel_t px;
    ratios = '{17'd6554, 17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd1, 17'd65535};
    idle_pct = '{0, 83, 0, 17};
    stall_pct = '{0, 0, 83, 17};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: no cloud, extremes, equal gray ties, alternating cloud flags.
    pending_pixels.insert(pending_pixels.size(),
                          pixel_t'{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    pending_pixels.insert(pending_pixels.size(),
                          pixel_t'{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    for (int i = 0; i < 12; i++) begin
      px = pixel_t'{1'b1, 8'd128, 8'(i * 21), 8'(255 - i * 20), 8'(i), i == 11};
      pending_pixels.insert(pending_pixels.size(), px);
    end
    for (int i = 0; i < 10; i++) begin
      px = pixel_t'{i[0], 8'(i * 28), 8'hAA, 8'h55, 8'hFF, i == 9};
      pending_pixels.insert(pending_pixels.size(), px);
    end
    drain();

    // Random frames across ratio settings and idling phases.
    for (int s = 0; s < 7; s++) begin
      write_ratio(ratios[s]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct = idle_pct[ph];
        recv_stall_pct = stall_pct[ph];
        for (int f = 0; f < 5; f++) queue_frame($urandom_range(20, 1));
        if (s == 2 && ph == 0) hold_off_go = 1'b1;
        drain();
      end
    end
    // One larger frame at the all-pixels ratio.
    write_ratio(17'd65536);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_frame(150);
    drain();

    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== top_fraction_color_average.f =====
+incdir+src
src/cfa_pkg.sv
src/cfa_if.sv
src/cfa_ram.sv
src/cfa_div.sv
src/top_fraction_color_average.sv
test/top_fraction_color_average_tb.sv
